[rtl/core/bpt_pkg.sv]
// breakpoint table shared package: widths, function codes, request/result types
// and controller/datapath command and status structs
// no dependencies
package bpt_pkg;

    localparam int ENTRIES    = 128;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int ADDR_BITS  = 8;
    localparam int ADDR_W     = 8;
    localparam int NAME_BYTES = 8;
    localparam int NAME_W     = 64;
    localparam int FUNC_W     = 3;
    localparam int ENTRY_W    = ADDR_W + NAME_W;

    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((1 << ADDR_BITS) - 1);

    localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEL_ADDR  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DEL_NAME  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FIND_ADDR = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FIND_NAME = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] address;
        logic [NAME_W-1:0] name;
    } bpt_req_t;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  match_index;
        logic [ADDR_W-1:0] match_address;
        logic [NAME_W-1:0] match_name;
        logic [CNT_W-1:0]  entry_count;
    } bpt_rsp_t;

    typedef struct packed {
        logic load;
        logic clear_cnt;
        logic scan_start;
        logic scan_step;
        logic shift_start;
        logic shift_step;
        logic ins_write;
        logic dec_cnt;
        logic res_load;
        logic res_ok;
    } bpt_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              hit;
        logic              sweep_done;
        logic              out_free;
    } bpt_status_t;

    function automatic logic [ADDR_W-1:0] norm_addr(input logic [ADDR_W-1:0] a);
        return a & ADDR_MASK;
    endfunction

    // bytes after the first zero byte are dropped
    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] n);
        logic [NAME_W-1:0] o;
        logic              live;
        o    = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (n[8*b +: 8] == 8'd0)
                live = 1'b0;
            if (live)
                o[8*b +: 8] = n[8*b +: 8];
        end
        return o;
    endfunction

endpackage

[rtl/core/bpt_ram.sv]
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module bpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/bpt_datapath.sv]
// breakpoint table datapath: key registers, entry ram, scan/shift pointers,
// hit capture and result register; depends on bpt_pkg and bpt_ram
module bpt_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpt_pkg::bpt_req_t    req,
    input  bpt_pkg::bpt_cmd_t    cmd,
    output bpt_pkg::bpt_status_t status,
    output bpt_pkg::bpt_rsp_t    result,
    output logic                 result_valid,
    input  logic                 result_stall
);
    import bpt_pkg::*;

    logic [FUNC_W-1:0]  func_reg;
    logic [ADDR_W-1:0]  key_addr_reg, key_addr_next;
    logic [NAME_W-1:0]  key_name_reg, key_name_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [ADDR_W-1:0]  hit_addr_reg, hit_addr_next;
    logic [NAME_W-1:0]  hit_name_reg, hit_name_next;
    logic               out_valid_reg, out_valid_next;
    bpt_rsp_t           out_reg, out_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic [NAME_W-1:0]  rd_name;
    logic               by_addr, by_name, addr_eq, name_eq, match, more, step, out_free;

    bpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_addr = ram_rdata[ENTRY_W-1:NAME_W];
    assign rd_name = ram_rdata[NAME_W-1:0];
    assign by_addr = (func_reg == FN_DEL_ADDR) || (func_reg == FN_FIND_ADDR);
    assign by_name = (func_reg == FN_DEL_NAME) || (func_reg == FN_FIND_NAME);
    assign addr_eq = (rd_addr == key_addr_reg);
    assign name_eq = (rd_name == key_name_reg);
    assign more    = (ptr_reg < count_reg);
    assign step    = cmd.scan_step || cmd.shift_step;
    assign out_free = !out_valid_reg || !result_stall;

    // insert refuses on a duplicate of either key
    always_comb
    begin
        if (by_addr)
            match = pend_reg && addr_eq;
        else if (by_name)
            match = pend_reg && name_eq;
        else
            match = pend_reg && (addr_eq || name_eq);
    end

    assign ram_we    = (cmd.shift_step && pend_reg) || cmd.ins_write;
    assign ram_waddr = cmd.ins_write ? count_reg[IDX_W-1:0] : pend_idx_reg - IDX_W'(1);
    assign ram_wdata = cmd.ins_write ? {key_addr_reg, key_name_reg} : ram_rdata;

    always_comb
    begin
        key_addr_next = key_addr_reg;
        key_name_next = key_name_reg;
        if (cmd.load)
        begin
            key_addr_next = norm_addr(req.address);
            key_name_next = norm_name(req.name);
        end

        count_next = count_reg;
        if (cmd.clear_cnt)
            count_next = '0;
        else if (cmd.ins_write)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.dec_cnt)
            count_next = count_reg - CNT_W'(1);

        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        if (cmd.scan_start)
        begin
            ptr_next  = '0;
            pend_next = 1'b0;
        end
        else if (cmd.shift_start)
        begin
            ptr_next  = CNT_W'(pend_idx_reg) + CNT_W'(1);
            pend_next = 1'b0;
        end
        else if (step)
        begin
            pend_next = more;
            if (more)
            begin
                ptr_next      = ptr_reg + CNT_W'(1);
                pend_idx_next = ptr_reg[IDX_W-1:0];
            end
        end

        hit_idx_next  = hit_idx_reg;
        hit_addr_next = hit_addr_reg;
        hit_name_next = hit_name_reg;
        if (cmd.load)
        begin
            hit_idx_next  = '0;
            hit_addr_next = '0;
            hit_name_next = '0;
        end
        else if (cmd.scan_step && match)
        begin
            hit_idx_next  = pend_idx_reg;
            hit_addr_next = rd_addr;
            hit_name_next = rd_name;
        end
        else if (cmd.ins_write)
        begin
            hit_idx_next  = count_reg[IDX_W-1:0];
            hit_addr_next = key_addr_reg;
            hit_name_next = key_name_reg;
        end

        out_next = out_reg;
        if (cmd.res_load)
        begin
            out_next.ok            = cmd.res_ok;
            out_next.match_index   = cmd.res_ok ? hit_idx_reg : '0;
            out_next.match_address = cmd.res_ok ? hit_addr_reg : '0;
            out_next.match_name    = cmd.res_ok ? hit_name_reg : '0;
            out_next.entry_count   = count_reg;
        end

        if (cmd.res_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg      <= FN_CLEAR;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                func_reg <= req.func;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_addr_reg <= key_addr_next;
        key_name_reg <= key_name_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_addr_reg <= hit_addr_next;
        hit_name_reg <= hit_name_next;
        out_reg      <= out_next;
    end

    assign status.func       = func_reg;
    assign status.full       = (count_reg == CNT_W'(ENTRIES));
    assign status.hit        = match;
    assign status.sweep_done = !pend_reg && !more;
    assign status.out_free   = out_free;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

[rtl/core/bpt_ctrl.sv]
// breakpoint table controller: state machine that sequences decode, scan,
// shift, insert and result; depends on bpt_pkg
module bpt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  bpt_pkg::bpt_status_t status,
    output bpt_pkg::bpt_cmd_t    cmd
);
    import bpt_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_INSERT = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ok_reg, ok_next;
    logic       is_delete;

    assign req_stall = (state_reg != ST_IDLE);
    assign is_delete = (status.func == FN_DEL_ADDR) || (status.func == FN_DEL_NAME);

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        cmd.res_ok = ok_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.func)
                    FN_CLEAR:
                    begin
                        cmd.clear_cnt = 1'b1;
                        ok_next       = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    FN_INSERT:
                    begin
                        ok_next = 1'b0;
                        if (status.full)
                            state_next = ST_RESULT;
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    FN_DEL_ADDR, FN_DEL_NAME, FN_FIND_ADDR, FN_FIND_NAME:
                    begin
                        ok_next        = 1'b0;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    default:
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.hit)
                begin
                    if (status.func == FN_INSERT)
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else if (is_delete)
                    begin
                        ok_next         = 1'b1;
                        cmd.shift_start = 1'b1;
                        state_next      = ST_SHIFT;
                    end
                    else
                    begin
                        ok_next    = 1'b1;
                        state_next = ST_RESULT;
                    end
                end
                else if (status.sweep_done)
                begin
                    if (status.func == FN_INSERT)
                        state_next = ST_INSERT;
                    else
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (status.sweep_done)
                begin
                    cmd.dec_cnt = 1'b1;
                    state_next  = ST_RESULT;
                end
            end
            ST_INSERT:
            begin
                cmd.ins_write = 1'b1;
                ok_next       = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

endmodule

[rtl/core/breakpoint_table_unit.sv]
// breakpoint table top level: ties the controller to the datapath and the ports
// depends on bpt_pkg, bpt_ctrl, bpt_datapath (and bpt_ram below it)

// An ordered table of up to 128 breakpoints (8-bit address, 8-byte name) held in
// a single-port-write, registered-read ram. One request is worked at a time and
// gives exactly one result. The table is searched one entry per cycle through the
// ram read port. An insert writes the new entry at the end once its search has
// found no duplicate. A delete that hits at index i then moves the later entries
// down one per cycle. Clear, an unused function code and an insert into a full
// table skip the search. The next request is taken as soon as the result is in
// the output register, even while it waits to be taken. No clearing pass is
// needed after reset: entries at or above the count are never read.
module breakpoint_table_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  bpt_pkg::bpt_req_t req,
    output logic              result_valid,
    input  logic              result_stall,
    output bpt_pkg::bpt_rsp_t result
);
    import bpt_pkg::*;

    // command and status between the two halves
    bpt_cmd_t    cmd;
    bpt_status_t status;

    // sequencing: decode, scan, shift on delete, append on insert
    bpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // entry storage, compare and result register
    bpt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // a request takes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("block not busy after accepting a request");

    // loading the result register always raises result valid
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> result_valid)
        else $error("result loaded but not presented");

    // the count never runs past the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.entry_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    // a failed request reports zero index, address and name
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.ok |->
            result.match_index == '0 && result.match_address == '0 &&
            result.match_name == '0)
        else $error("failed request with nonzero match fields");

endmodule

[tb/sv/tb_breakpoint_table_unit.sv]
// self-checking testbench for breakpoint_table_unit: directed and random requests,
// predicted in-line by a behavioral copy of the breakpoint table
// depends on bpt_pkg and the breakpoint_table_unit rtl
module tb_breakpoint_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import bpt_pkg::*;

    // function codes the block must ignore
    localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

    localparam int MAX_PRINTED   = 32;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;

    // clock, reset and ports
    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    bpt_req_t  req;
    logic      result_valid;
    logic      result_stall;
    bpt_rsp_t  result;

    // behavioral copy of the table, updated when a request is accepted
    logic [ADDR_W-1:0] tbl_addr [ENTRIES];
    logic [NAME_W-1:0] tbl_name [ENTRIES];
    int                tbl_count;

    // results still owed by the block, oldest first
    bpt_rsp_t          owed_results [$];
    bpt_rsp_t          got_want;

    // idling knobs, in percent per cycle
    int send_gap_pct;
    int stall_pct;

    // long receiver hold-off, asked by a test and counted by the receiver process
    int hold_request;
    int hold_left;

    // bookkeeping
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int deepest_table;
    int full_refusals;
    int shifting_deletes;
    int hold_cycles_done;

    breakpoint_table_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // table prediction
    // ------------------------------------------------------------------

    // a name is a string: everything from the first zero byte on is dropped
    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] kept;
        kept = '0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                break;
            kept[8*b +: 8] = raw[8*b +: 8];
        end
        return kept;
    endfunction

    function automatic int slot_of_addr(input logic [ADDR_W-1:0] a);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_addr[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int slot_of_name(input logic [NAME_W-1:0] n);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_name[i] == n)
                return i;
        return -1;
    endfunction

    // apply one accepted request to the table copy and return its result
    function automatic bpt_rsp_t apply_table_op(input bpt_req_t r);
        bpt_rsp_t          o;
        logic [ADDR_W-1:0] a;
        logic [NAME_W-1:0] n;
        int                hit;
        o   = '0;
        a   = r.address & ADDR_MASK;
        n   = trim_name(r.name);
        hit = -1;
        case (r.func)
            FN_INSERT:
            begin
                if (tbl_count >= ENTRIES)
                    full_refusals++;
                else if (slot_of_addr(a) < 0 && slot_of_name(n) < 0)
                begin
                    tbl_addr[tbl_count] = a;
                    tbl_name[tbl_count] = n;
                    o.ok            = 1'b1;
                    o.match_index   = IDX_W'(tbl_count);
                    o.match_address = a;
                    o.match_name    = n;
                    tbl_count++;
                end
            end
            FN_DEL_ADDR, FN_DEL_NAME, FN_FIND_ADDR, FN_FIND_NAME:
            begin
                if (r.func == FN_DEL_ADDR || r.func == FN_FIND_ADDR)
                    hit = slot_of_addr(a);
                else
                    hit = slot_of_name(n);
                if (hit >= 0)
                begin
                    o.ok            = 1'b1;
                    o.match_index   = IDX_W'(hit);
                    o.match_address = tbl_addr[hit];
                    o.match_name    = tbl_name[hit];
                    if (r.func == FN_DEL_ADDR || r.func == FN_DEL_NAME)
                    begin
                        // later entries close the gap
                        if (hit < tbl_count - 1)
                            shifting_deletes++;
                        for (int i = hit; i < tbl_count - 1; i++)
                        begin
                            tbl_addr[i] = tbl_addr[i+1];
                            tbl_name[i] = tbl_name[i+1];
                        end
                        tbl_count--;
                    end
                end
            end
            FN_CLEAR:
            begin
                tbl_count = 0;
                o.ok      = 1'b1;
            end
            default:
            begin
                // unused codes leave the table alone
            end
        endcase
        o.entry_count = CNT_W'(tbl_count);
        if (tbl_count > deepest_table)
            deepest_table = tbl_count;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one request after a random gap, hold it until taken, then predict
    task automatic send_request(input bpt_req_t item);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        owed_results.push_back(apply_table_op(item));
        requests_sent++;
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain_results(input int settle);
        @(negedge clk);
        req_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    function automatic bpt_req_t mk_req(input logic [FUNC_W-1:0] fn,
                                        input logic [ADDR_W-1:0] a,
                                        input logic [NAME_W-1:0] n);
        bpt_req_t r;
        r.func    = fn;
        r.address = a;
        r.name    = n;
        return r;
    endfunction

    // random name: mostly a clean string of 1..8 bytes, sometimes with junk
    // after the terminating zero, sometimes raw bits or empty
    function automatic logic [NAME_W-1:0] rand_name();
        logic [NAME_W-1:0] n;
        int                len;
        bit                junk;
        n = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 8)
            return n;
        len  = ($urandom_range(0, 99) < 3) ? 0 : $urandom_range(1, NAME_BYTES);
        junk = ($urandom_range(0, 1) == 1);
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (b < len)
                n[8*b +: 8] = 8'($urandom_range(1, 255));
            else if (b == len || !junk)
                n[8*b +: 8] = 8'h00;
        end
        return n;
    endfunction

    // same string as a stored name, but with fresh junk after its terminator
    function automatic logic [NAME_W-1:0] alias_name(input logic [NAME_W-1:0] stored);
        logic [NAME_W-1:0] n;
        bit                past_end;
        n        = stored;
        past_end = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (stored[8*b +: 8] == 8'h00)
            begin
                if (past_end)
                    n[8*b +: 8] = 8'($urandom);
                past_end = 1'b1;
            end
        end
        return n;
    endfunction

    // build a request whose key hits a live entry hit_pct percent of the time
    function automatic bpt_req_t keyed_req(input logic [FUNC_W-1:0] fn, input int hit_pct);
        bpt_req_t r;
        int       slot;
        bit       by_addr;
        r       = mk_req(fn, ADDR_W'($urandom), rand_name());
        by_addr = (fn == FN_DEL_ADDR || fn == FN_FIND_ADDR) ||
                  (fn == FN_INSERT && $urandom_range(0, 1));
        if (tbl_count > 0 && $urandom_range(0, 99) < hit_pct)
        begin
            slot = $urandom_range(0, tbl_count - 1);
            if (by_addr)
                r.address = tbl_addr[slot];
            else if ($urandom_range(0, 1))
                r.name = alias_name(tbl_name[slot]);
            else
                r.name = tbl_name[slot];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver stall: random, or held high for a counted stretch when asked
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
            hold_cycles_done++;
        end
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic report_mismatch(input string what,
                                   input logic [NAME_W-1:0] got,
                                   input logic [NAME_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
    endtask

    // compare every taken result with the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (owed_results.size() == 0)
                report_mismatch("result with no request owed", NAME_W'(result), '0);
            else
            begin
                got_want = owed_results.pop_front();
                if (result.ok !== got_want.ok)
                    report_mismatch("ok", NAME_W'(result.ok), NAME_W'(got_want.ok));
                if (result.match_index !== got_want.match_index)
                    report_mismatch("match_index", NAME_W'(result.match_index),
                                    NAME_W'(got_want.match_index));
                if (result.match_address !== got_want.match_address)
                    report_mismatch("match_address", NAME_W'(result.match_address),
                                    NAME_W'(got_want.match_address));
                if (result.match_name !== got_want.match_name)
                    report_mismatch("match_name", result.match_name, got_want.match_name);
                if (result.entry_count !== got_want.entry_count)
                    report_mismatch("entry_count", NAME_W'(result.entry_count),
                                    NAME_W'(got_want.entry_count));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes, every function code and the string / duplicate / empty cases
    task automatic test_directed();
        send_request(mk_req(FN_FIND_ADDR, 8'h10, 64'h41));                  // empty table
        send_request(mk_req(FN_DEL_NAME,  8'h00, 64'h78));                  // empty table
        send_request(mk_req(FN_INSERT,    8'h00, 64'h41));                  // "A" at 0
        send_request(mk_req(FN_INSERT,    8'hFF, 64'hFFFF_FFFF_FFFF_FFFF)); // full-width name
        send_request(mk_req(FN_INSERT,    8'h5A, 64'hDEAD_BEEF_C300_5042)); // "BP" plus junk
        send_request(mk_req(FN_INSERT,    8'hFF, 64'h51));                  // address taken
        send_request(mk_req(FN_INSERT,    8'h33, 64'h7700_0000_0000_0041)); // "A" taken
        send_request(mk_req(FN_FIND_NAME, 8'h00, 64'h1234_0000_0000_5042)); // "BP", other junk
        send_request(mk_req(FN_FIND_ADDR, 8'hFF, 64'h0));
        send_request(mk_req(FN_FIND_NAME, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk_req(FN_FIND_ADDR, 8'h77, 64'h0));                   // miss
        send_request(mk_req(FN_FIND_NAME, 8'h00, 64'h42));                  // "B" is not "BP"
        send_request(mk_req(FN_DEL_NAME,  8'h00, 64'h43));                  // miss, non-empty
        send_request(mk_req(FN_INSERT,    8'h80, 64'h0));                   // empty name
        send_request(mk_req(FN_FIND_NAME, 8'h00, 64'hFFFF_FFFF_FFFF_FF00)); // trims to empty
        send_request(mk_req(FN_DEL_ADDR,  8'h00, 64'h0));                   // head, all shift
        send_request(mk_req(FN_FIND_ADDR, 8'hFF, 64'h0));                   // moved to 0
        send_request(mk_req(FN_DEL_NAME,  8'h00, 64'h5042));
        send_request(mk_req(FN_DEL_ADDR,  8'h42, 64'h0));                   // miss
        send_request(mk_req(FN_UNUSED_6,  8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk_req(FN_UNUSED_7,  8'h00, 64'h0));
        send_request(mk_req(FN_CLEAR,     8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(mk_req(FN_FIND_ADDR, 8'hFF, 64'h0));                   // gone after clear
        send_request(mk_req(FN_INSERT,    8'hFF, 64'h0102_0304_0506_0708));
        send_request(mk_req(FN_DEL_NAME,  8'h00, 64'h0102_0304_0506_0708)); // back to empty
    endtask

    // fill to the last entry, refuse one more, then work at both ends
    task automatic test_table_full();
        logic [NAME_W-1:0] n;
        send_request(mk_req(FN_CLEAR, 8'h00, 64'h0));
        for (int i = 0; i <= ENTRIES; i++)
        begin
            // odd stride keeps addresses distinct, byte 0 keeps names distinct
            n            = {$urandom, $urandom};
            n[7:0]       = 8'(i + 1);
            send_request(mk_req(FN_INSERT, 8'((i * 37 + 5) & 8'hFF), n));
        end
        send_request(keyed_req(FN_INSERT, 100));                            // full and duplicate
        send_request(mk_req(FN_FIND_ADDR, tbl_addr[ENTRIES-1], 64'h0));
        send_request(mk_req(FN_FIND_NAME, 8'h00, tbl_name[ENTRIES/2]));
        send_request(mk_req(FN_DEL_ADDR, tbl_addr[0], 64'h0));              // longest shift
        send_request(mk_req(FN_DEL_NAME, 8'h00, tbl_name[tbl_count-1]));    // tail, no shift
        send_request(mk_req(FN_INSERT, 8'((ENTRIES * 37 + 5) & 8'hFF), 64'h4E45_5750));
        send_request(mk_req(FN_CLEAR, 8'h00, 64'h0));
    endtask

    // weighted mix of well-formed traffic plus a few percent of raw noise
    task automatic test_random_ops(input int count);
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 999);
            if (pick < 420)
                send_request(keyed_req(FN_INSERT, 15));
            else if (pick < 540)
                send_request(keyed_req(FN_DEL_ADDR, 80));
            else if (pick < 660)
                send_request(keyed_req(FN_DEL_NAME, 80));
            else if (pick < 800)
                send_request(keyed_req(FN_FIND_ADDR, 75));
            else if (pick < 955)
                send_request(keyed_req(FN_FIND_NAME, 75));
            else if (pick < 960)
                send_request(mk_req(FN_CLEAR, ADDR_W'($urandom), {$urandom, $urandom}));
            else
                send_request(mk_req(FUNC_W'($urandom_range(0, 7)), ADDR_W'($urandom),
                                    {$urandom, $urandom}));
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and the block stalls its input
    task automatic test_stall_pressure();
        int saved_gap;
        saved_gap     = send_gap_pct;
        send_gap_pct  = 0;
        hold_request  = HOLD_CYCLES;
        for (int k = 0; k < 12; k++)
            send_request(keyed_req((k % 2 == 0) ? FN_FIND_ADDR : FN_INSERT, 60));
        send_gap_pct  = saved_gap;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req              = '0;
        result_stall     = 1'b0;
        tbl_count        = 0;
        send_gap_pct     = 0;
        stall_pct        = 0;
        hold_request     = 0;
        hold_left        = 0;
        mismatch_count   = 0;
        requests_sent    = 0;
        results_checked  = 0;
        deepest_table    = 0;
        full_refusals    = 0;
        shifting_deletes = 0;
        hold_cycles_done = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalling
        send_gap_pct = 14;
        stall_pct    = 78;
        test_directed();
        test_table_full();
        test_random_ops(400);
        drain_results(8);

        // sender mostly idle, receiver mostly ready
        send_gap_pct = 78;
        stall_pct    = 14;
        test_random_ops(400);
        test_stall_pressure();
        drain_results(8);

        // back to back on both sides
        send_gap_pct = 0;
        stall_pct    = 0;
        test_random_ops(400);
        drain_results(SETTLE_CYCLES);

        if (owed_results.size() != 0)
            report_mismatch("results never delivered", NAME_W'(owed_results.size()), '0);

        $display("covered: %0d requests, %0d results checked, table depth up to %0d",
                 requests_sent, results_checked, deepest_table);
        $display("covered: %0d inserts refused when full, %0d deletes with a shift, %0d %s",
                 full_refusals, shifting_deletes, hold_cycles_done, "hold-off cycles");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #40_000_000;
        $display("timeout: %0d results still owed", owed_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/core/bpt_pkg.sv
rtl/core/bpt_ram.sv
rtl/core/bpt_datapath.sv
rtl/core/bpt_ctrl.sv
rtl/core/breakpoint_table_unit.sv
tb/sv/tb_breakpoint_table_unit.sv
